/* rtl/dqs_pkg.sv */
// shared widths, operation and status codes for the deque with value search
package dqs_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_POP_FRONT = 3'd1,
    OP_POP_BACK  = 3'd2,
    OP_FIND      = 3'd3,
    OP_CLEAR     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

endpackage

/* rtl/dqs_if.sv */
// request and response channel interfaces of the deque with value search
interface dqs_req_if;
  import dqs_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dqs_rsp_if;
  import dqs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink   (input valid, input status, input position, input count, output ready);
endinterface

/* rtl/deque_with_value_search_core.sv */
// deque of signed 32-bit values in a ring buffer ram, with a front-to-back value search
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    operation[2:0], value[31:0] signed
//   rsp_o    out  valid/ready    status[1:0], position[5:0], count[6:0]
//
// append, removes, clear and unused codes: the result register loads as the transaction is taken
// find: the first ram read is issued as the transaction is taken, then one stored entry
//   per cycle is compared from the front until a match or the last held entry
// the single-port-read ram sets the find rate; one item is in work at a time
// reset clears state, head, count and the result valid flag only; ram contents stay undefined until written
// a stalled result holds the block's input; a new transaction is taken as the result leaves
module deque_with_value_search_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dqs_req_if.sink    req_i,
  dqs_rsp_if.source  rsp_o
);
  import dqs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned PW = (AW > POS_W) ? AW : POS_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [VALUE_W-1:0]  key_q, key_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic                rsp_valid_q, rsp_valid_d;
  status_e             rsp_status_q, rsp_status_d;
  logic [POS_W-1:0]    rsp_pos_q, rsp_pos_d;
  logic [COUNT_W-1:0]  rsp_count_q, rsp_count_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;
  logic                accept, rsp_load, is_full, is_empty;
  logic [AW-1:0]       next_addr;

  // ring index add, both operands below DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(logic [CW-1:0] c);
    logic [XW-1:0] x;
    x = XW'(c);
    return x[COUNT_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] to_pos(logic [AW-1:0] p);
    logic [PW-1:0] x;
    x = PW'(p);
    return x[POS_W-1:0];
  endfunction

  dqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready    = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept         = req_i.valid && req_i.ready;
  assign is_full        = (count_q == CW'(DEPTH));
  assign is_empty       = (count_q == '0);
  assign next_addr      = wrap_add(addr_q, AW'(1));

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.position = rsp_pos_q;
  assign rsp_o.count    = rsp_count_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    key_d        = key_q;
    idx_d        = idx_q;
    addr_d       = addr_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_pos_d    = rsp_pos_q;
    rsp_count_d  = rsp_count_q;
    rsp_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wrap_add(head_q, count_q[AW-1:0]);
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rsp_load     = 1'b1;
          rsp_status_d = STAT_OK;
          rsp_pos_d    = '0;
          case (op_e'(req_i.operation))
            OP_APPEND: begin
              if (is_full) begin
                rsp_status_d = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                rsp_status_d = STAT_EMPTY;
              end else begin
                head_d  = wrap_add(head_q, AW'(1));
                count_d = count_q - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                rsp_status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            OP_FIND: begin
              if (is_empty) begin
                rsp_status_d = STAT_MISSING;
              end else begin
                // first read goes out now, compare starts next cycle
                rsp_load = 1'b0;
                ram_re   = 1'b1;
                key_d    = req_i.value;
                addr_d   = head_q;
                idx_d    = '0;
                state_d  = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ram_rdata == key_q) begin
          rsp_load     = 1'b1;
          rsp_status_d = STAT_OK;
          rsp_pos_d    = to_pos(idx_q);
          state_d      = ST_IDLE;
        end else if ((CW'(idx_q) + CW'(1)) == count_q) begin
          rsp_load     = 1'b1;
          rsp_status_d = STAT_MISSING;
          rsp_pos_d    = '0;
          state_d      = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = next_addr;
          addr_d    = next_addr;
          idx_d     = idx_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (rsp_load) begin
      rsp_valid_d = 1'b1;
      rsp_count_d = to_count(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    idx_q        <= idx_d;
    addr_q       <= addr_d;
    rsp_status_q <= rsp_status_d;
    rsp_pos_q    <= rsp_pos_d;
    rsp_count_q  <= rsp_count_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("held count above depth");

  a_scan_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !rsp_valid_q)
    else $error("response pending during scan");

  a_scan_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(idx_q) < count_q))
    else $error("scan index outside held window");

  a_scan_keeps_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> ($stable(count_q) && $stable(head_q)))
    else $error("store changed during scan");

  a_find_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.operation == OP_FIND) && !is_empty) |=> (state_q == ST_SCAN))
    else $error("find on non-empty store did not start a scan");

endmodule

/* rtl/dqs_ram.sv */
// generic single write port, single read port ram with registered read data
module dqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
